/* rtl/arp_cache_with_pending_requests_core_macros.svh */
// Assertion macros for the ARP cache core.
`ifndef ARP_CACHE_WITH_PENDING_REQUESTS_CORE_MACROS_SVH
`define ARP_CACHE_WITH_PENDING_REQUESTS_CORE_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ARPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ARPC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

/* rtl/arpc_pkg.sv */
// Shared types, codes and defaults of the ARP cache core.
package arpc_pkg;

	localparam int CACHE_ENTRIES_DEF = 32;
	localparam int REQ_SLOTS_DEF = 8;
	localparam int PKT_SLOTS_DEF = 32;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_APPEND = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	localparam logic [2:0] KIND_HIT = 3'd0;
	localparam logic [2:0] KIND_MISS = 3'd1;
	localparam logic [2:0] KIND_SEND = 3'd2;
	localparam logic [2:0] KIND_FWD = 3'd3;
	localparam logic [2:0] KIND_UNREACH = 3'd4;
	localparam logic [2:0] KIND_DROP = 3'd5;

	localparam logic [1:0] REG_ENTRY_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

	localparam logic [15:0] ENTRY_TIMEOUT_RST = 16'd15;
	localparam logic [7:0] RETRY_INTERVAL_RST = 8'd1;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
		logic [3:0] iface_id;
		logic [15:0] pkt_handle;
		logic [10:0] pkt_len;
	} in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [47:0] mac_out;
		logic [31:0] ip_out;
		logic [3:0] iface_out;
		logic [15:0] handle_out;
		logic [10:0] len_out;
		logic last;
	} out_t;

	typedef struct packed {
		logic push;
		logic flush;
		out_t res;
	} emit_req_t;

	typedef struct packed {
		logic room;
		logic pend;
	} emit_sts_t;

endpackage

/* rtl/arpc_emit.sv */
// Result stage: holds one result back to mark the final one, then drives the output register.
module arpc_emit (
	input logic clk,
	input logic arst_n,
	input arpc_pkg::emit_req_t req,
	output arpc_pkg::emit_sts_t sts,
	output logic out_valid,
	input logic out_stall,
	output arpc_pkg::out_t out_item
);

	logic ov_q;
	logic pv_q;
	arpc_pkg::out_t pend_q;
	arpc_pkg::out_t out_q;
	arpc_pkg::out_t mv;
	logic out_free;
	logic room;
	logic mv_en;

	assign out_free = !ov_q || !out_stall;
	assign room = !pv_q || out_free;
	assign sts.room = room;
	assign sts.pend = pv_q;
	assign out_valid = ov_q;
	assign out_item = out_q;

	// the held result is the last one only when it leaves on a flush
	always_comb begin
		mv = pend_q;
		mv.last = !req.push;
	end
	assign mv_en = room && pv_q && (req.push || req.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			pv_q <= 1'b0;
		end else begin
			if (mv_en) begin
				ov_q <= 1'b1;
				out_q <= mv;
			end else if (out_free) begin
				ov_q <= 1'b0;
			end
			if (req.push && room) begin
				pend_q <= req.res;
				pv_q <= 1'b1;
			end else if (mv_en) begin
				pv_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/arp_cache_with_pending_requests_core.sv */
// Top level of the ARP cache core with pending address requests.
// Usage:
// One input channel (in_valid/in_stall, in_item) takes commands: lookup,
// insert, append packet and time tick. One output channel (out_valid/
// out_stall, out_item) gives result items; last marks the final result of a
// command. Insert, tick and an append that joins a pending request may give no result at all.
// Commands run one at a time under a sequencer that walks the stores with a
// single shared address compare, one slot per cycle unless a result waits
// for room in the result stage. Each drained packet needs its own scan of
// the packet slots. in_stall is high while a command runs.
// Results pass through a one-deep hold stage and an output register; a
// stalled receiver halts the sequencer when both are full.
// Reset clears all valid bits, the tick counter and the registers to their
// defaults; the cfg port writes a register by index at any time.
`include "arp_cache_with_pending_requests_core_macros.svh"
module arp_cache_with_pending_requests_core #(
	parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
	parameter int REQ_SLOTS = arpc_pkg::REQ_SLOTS_DEF,
	parameter int PKT_SLOTS = arpc_pkg::PKT_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input arpc_pkg::in_t in_item,
	output logic out_valid,
	input logic out_stall,
	output arpc_pkg::out_t out_item,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data
);

	localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RW = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;
	localparam int PW = (PKT_SLOTS > 1) ? $clog2(PKT_SLOTS) : 1;
	localparam int NW = $clog2(PKT_SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_INS, S_AGE, S_REQ, S_DRAIN, S_AREQ, S_APKT, S_ADO, S_FIN
	} state_t;

	state_t st_q;
	arpc_pkg::in_t cur_q;
	logic [15:0] timeout_q;
	logic [7:0] interval_q;
	logic [3:0] limit_q;
	logic [31:0] now_q;
	logic [CW-1:0] e_q;
	logic [RW-1:0] r_q;
	logic [PW-1:0] p_q;
	logic [NW-1:0] pos_q;
	logic hit_f_q, free_f_q, pfree_q;
	logic [RW-1:0] hr_q, fr_q;
	logic [PW-1:0] fp_q;

	logic [CACHE_ENTRIES-1:0] entry_valid_q;
	logic [31:0] entry_ip_q [CACHE_ENTRIES];
	logic [47:0] entry_mac_q [CACHE_ENTRIES];
	logic [31:0] entry_added_q [CACHE_ENTRIES];
	logic [REQ_SLOTS-1:0] req_valid_q;
	logic [31:0] req_ip_q [REQ_SLOTS];
	logic [3:0] req_iface_q [REQ_SLOTS];
	logic [31:0] req_sent_q [REQ_SLOTS];
	logic [3:0] req_retries_q [REQ_SLOTS];
	logic [NW-1:0] req_count_q [REQ_SLOTS];
	logic [PKT_SLOTS-1:0] pkt_valid_q;
	logic [RW-1:0] pkt_owner_q [PKT_SLOTS];
	logic [15:0] pkt_ref_q [PKT_SLOTS];
	logic [10:0] pkt_bytes_q [PKT_SLOTS];
	logic [NW-1:0] pkt_order_q [PKT_SLOTS];

	arpc_pkg::emit_req_t ereq;
	arpc_pkg::emit_sts_t ests;

	logic e_last, r_last, p_last;
	logic ip_cmp_eq;
	logic [31:0] ip_cmp_a;
	logic e_hit, rbase, age_ok, can_retry, pmatch, drain_done;
	logic fresh, drop;
	logic [RW-1:0] rr;

	assign e_last = (e_q == CW'(CACHE_ENTRIES - 1));
	assign r_last = (r_q == RW'(REQ_SLOTS - 1));
	assign p_last = (p_q == PW'(PKT_SLOTS - 1));

	// shared address compare: entry address or request address against the command
	always_comb begin
		unique case (st_q)
			S_LOOK: ip_cmp_a = entry_ip_q[e_q];
			default: ip_cmp_a = req_ip_q[r_q];
		endcase
	end
	assign ip_cmp_eq = (ip_cmp_a == cur_q.ip_addr);

	assign e_hit = entry_valid_q[e_q] && ip_cmp_eq;
	assign rbase = req_valid_q[r_q] && (req_count_q[r_q] != '0);
	assign age_ok = ((now_q - req_sent_q[r_q]) >= {24'd0, interval_q});
	assign can_retry = (req_retries_q[r_q] < limit_q);
	assign drain_done = (pos_q == req_count_q[r_q]);
	assign pmatch = pkt_valid_q[p_q] && (pkt_owner_q[p_q] == r_q)
		&& (pkt_order_q[p_q] == pos_q);
	assign fresh = !hit_f_q;
	assign drop = !pfree_q || (!hit_f_q && !free_f_q);
	assign rr = hit_f_q ? hr_q : fr_q;

	always_comb begin
		ereq = '0;
		ereq.res.ip_out = cur_q.ip_addr;
		ereq.flush = (st_q == S_FIN);
		unique case (st_q)
			S_LOOK: begin
				if (e_hit) begin
					ereq.push = 1'b1;
					ereq.res.kind = arpc_pkg::KIND_HIT;
					ereq.res.mac_out = entry_mac_q[e_q];
				end else if (e_last) begin
					ereq.push = 1'b1;
					ereq.res.kind = arpc_pkg::KIND_MISS;
				end
			end
			S_REQ: begin
				if (cur_q.cmd == arpc_pkg::CMD_TICK && rbase && age_ok && can_retry) begin
					ereq.push = 1'b1;
					ereq.res.kind = arpc_pkg::KIND_SEND;
					ereq.res.ip_out = req_ip_q[r_q];
					ereq.res.iface_out = req_iface_q[r_q];
				end
			end
			S_DRAIN: begin
				if (!drain_done && pmatch) begin
					ereq.push = 1'b1;
					ereq.res.ip_out = req_ip_q[r_q];
					ereq.res.iface_out = req_iface_q[r_q];
					ereq.res.handle_out = pkt_ref_q[p_q];
					ereq.res.len_out = pkt_bytes_q[p_q];
					if (cur_q.cmd == arpc_pkg::CMD_INSERT) begin
						ereq.res.kind = arpc_pkg::KIND_FWD;
						ereq.res.mac_out = cur_q.mac_addr;
					end else begin
						ereq.res.kind = arpc_pkg::KIND_UNREACH;
					end
				end
			end
			S_ADO: begin
				if (drop) begin
					ereq.push = 1'b1;
					ereq.res.kind = arpc_pkg::KIND_DROP;
					ereq.res.iface_out = cur_q.iface_id;
					ereq.res.handle_out = cur_q.pkt_handle;
					ereq.res.len_out = cur_q.pkt_len;
				end else if (fresh) begin
					ereq.push = 1'b1;
					ereq.res.kind = arpc_pkg::KIND_SEND;
					ereq.res.iface_out = cur_q.iface_id;
				end
			end
			default: ereq.push = 1'b0;
		endcase
	end

	arpc_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.req(ereq),
		.sts(ests),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	assign in_stall = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= arpc_pkg::ENTRY_TIMEOUT_RST;
			interval_q <= arpc_pkg::RETRY_INTERVAL_RST;
			limit_q <= arpc_pkg::RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				arpc_pkg::REG_ENTRY_TIMEOUT: timeout_q <= cfg_data;
				arpc_pkg::REG_RETRY_INTERVAL: interval_q <= cfg_data[7:0];
				arpc_pkg::REG_RETRY_LIMIT: limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			now_q <= '0;
			entry_valid_q <= '0;
			req_valid_q <= '0;
			pkt_valid_q <= '0;
			e_q <= '0;
			r_q <= '0;
			p_q <= '0;
			pos_q <= '0;
			hit_f_q <= 1'b0;
			free_f_q <= 1'b0;
			pfree_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_q <= in_item;
						e_q <= '0;
						r_q <= '0;
						hit_f_q <= 1'b0;
						free_f_q <= 1'b0;
						unique case (in_item.cmd)
							arpc_pkg::CMD_LOOKUP: st_q <= S_LOOK;
							arpc_pkg::CMD_INSERT: st_q <= S_INS;
							arpc_pkg::CMD_APPEND: st_q <= S_AREQ;
							arpc_pkg::CMD_TICK: begin
								now_q <= now_q + 32'd1;
								st_q <= S_AGE;
							end
						endcase
					end
				end
				S_LOOK: begin
					if (ereq.push) begin
						if (ests.room)
							st_q <= S_FIN;
					end else begin
						e_q <= e_q + CW'(1);
					end
				end
				S_INS: begin
					if (!entry_valid_q[e_q] || e_last) begin
						// full table: overwrite entry zero
						automatic logic [CW-1:0] w = entry_valid_q[e_q] ? '0 : e_q;
						entry_valid_q[w] <= 1'b1;
						entry_ip_q[w] <= cur_q.ip_addr;
						entry_mac_q[w] <= cur_q.mac_addr;
						entry_added_q[w] <= now_q;
						r_q <= '0;
						st_q <= S_REQ;
					end else begin
						e_q <= e_q + CW'(1);
					end
				end
				S_AGE: begin
					if (entry_valid_q[e_q]
						&& ((now_q - entry_added_q[e_q]) > {16'd0, timeout_q}))
						entry_valid_q[e_q] <= 1'b0;
					if (e_last) begin
						r_q <= '0;
						st_q <= S_REQ;
					end else begin
						e_q <= e_q + CW'(1);
					end
				end
				S_REQ: begin
					if (cur_q.cmd == arpc_pkg::CMD_INSERT) begin
						if (rbase && ip_cmp_eq) begin
							pos_q <= '0;
							p_q <= '0;
							st_q <= S_DRAIN;
						end else if (r_last) begin
							st_q <= S_FIN;
						end else begin
							r_q <= r_q + RW'(1);
						end
					end else if (rbase && age_ok && !can_retry) begin
						pos_q <= '0;
						p_q <= '0;
						st_q <= S_DRAIN;
					end else if (!ereq.push || ests.room) begin
						if (ereq.push) begin
							req_retries_q[r_q] <= req_retries_q[r_q] + 4'd1;
							req_sent_q[r_q] <= now_q;
						end
						if (r_last)
							st_q <= S_FIN;
						else
							r_q <= r_q + RW'(1);
					end
				end
				S_DRAIN: begin
					if (drain_done) begin
						req_valid_q[r_q] <= 1'b0;
						req_count_q[r_q] <= '0;
						if (r_last)
							st_q <= S_FIN;
						else begin
							r_q <= r_q + RW'(1);
							st_q <= S_REQ;
						end
					end else if (pmatch) begin
						if (ests.room) begin
							pkt_valid_q[p_q] <= 1'b0;
							pos_q <= pos_q + NW'(1);
							p_q <= '0;
						end
					end else begin
						p_q <= p_last ? '0 : p_q + PW'(1);
					end
				end
				S_AREQ: begin
					if (req_valid_q[r_q] && ip_cmp_eq && !hit_f_q) begin
						hit_f_q <= 1'b1;
						hr_q <= r_q;
					end
					if (!req_valid_q[r_q] && !free_f_q) begin
						free_f_q <= 1'b1;
						fr_q <= r_q;
					end
					if (r_last) begin
						p_q <= '0;
						st_q <= S_APKT;
					end else begin
						r_q <= r_q + RW'(1);
					end
				end
				S_APKT: begin
					if (!pkt_valid_q[p_q]) begin
						pfree_q <= 1'b1;
						fp_q <= p_q;
						st_q <= S_ADO;
					end else if (p_last) begin
						pfree_q <= 1'b0;
						st_q <= S_ADO;
					end else begin
						p_q <= p_q + PW'(1);
					end
				end
				S_ADO: begin
					if (!ereq.push || ests.room) begin
						if (!drop) begin
							if (fresh) begin
								req_valid_q[rr] <= 1'b1;
								req_ip_q[rr] <= cur_q.ip_addr;
								req_iface_q[rr] <= cur_q.iface_id;
								req_sent_q[rr] <= now_q;
								req_retries_q[rr] <= '0;
								req_count_q[rr] <= NW'(1);
								pkt_order_q[fp_q] <= '0;
							end else begin
								req_count_q[rr] <= req_count_q[rr] + NW'(1);
								pkt_order_q[fp_q] <= req_count_q[rr];
							end
							pkt_valid_q[fp_q] <= 1'b1;
							pkt_owner_q[fp_q] <= rr;
							pkt_ref_q[fp_q] <= cur_q.pkt_handle;
							pkt_bytes_q[fp_q] <= cur_q.pkt_len;
						end
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (ests.room)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`ARPC_ASSERT(a_tick_advance, (in_valid && !in_stall && in_item.cmd == arpc_pkg::CMD_TICK) |=> (now_q == $past(now_q) + 32'd1), "tick did not advance time")
	`ARPC_NEVER(a_idle_pending, (st_q == S_IDLE) && ests.pend, "result held while idle")
	`ARPC_ASSERT(a_push_hold, (ereq.push && !ests.room) |=> $stable(st_q), "sequencer moved on without room for its result")

endmodule

/* sim/tb_arp_cache_with_pending_requests_core.sv */
// Self-checking testbench for the ARP cache core with pending address requests.
module tb_arp_cache_with_pending_requests_core;

	localparam int N_ENT = arpc_pkg::CACHE_ENTRIES_DEF;
	localparam int N_REQ = arpc_pkg::REQ_SLOTS_DEF;
	localparam int N_PKT = arpc_pkg::PKT_SLOTS_DEF;
	localparam int SETTLE = 1500;
	localparam int WATCHDOG = 20000;

	// Tracks table state and holds the results the core owes us.
	class arp_scoreboard;
		bit ent_vld[N_ENT];
		logic [31:0] ent_ip[N_ENT];
		logic [47:0] ent_mac[N_ENT];
		logic [31:0] ent_born[N_ENT];
		bit req_vld[N_REQ];
		logic [31:0] req_ip[N_REQ];
		logic [3:0] req_if[N_REQ];
		logic [31:0] req_sent[N_REQ];
		logic [3:0] req_tries[N_REQ];
		bit pkt_vld[N_PKT];
		int pkt_req[N_PKT];
		logic [15:0] pkt_hdl[N_PKT];
		logic [10:0] pkt_len[N_PKT];
		int pkt_pos[N_PKT];
		logic [15:0] timeout;
		logic [7:0] interval;
		logic [3:0] limit;
		logic [31:0] ticks;
		arpc_pkg::out_t owed[$];
		arpc_pkg::out_t batch[$];
		int errors;

		function new();
			timeout = arpc_pkg::ENTRY_TIMEOUT_RST;
			interval = arpc_pkg::RETRY_INTERVAL_RST;
			limit = arpc_pkg::RETRY_LIMIT_RST;
			ticks = '0;
			errors = 0;
			foreach (ent_vld[i]) ent_vld[i] = 0;
			foreach (req_vld[i]) req_vld[i] = 0;
			foreach (pkt_vld[i]) pkt_vld[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				arpc_pkg::REG_ENTRY_TIMEOUT: timeout = val;
				arpc_pkg::REG_RETRY_INTERVAL: interval = val[7:0];
				arpc_pkg::REG_RETRY_LIMIT: limit = val[3:0];
				default: ;
			endcase
		endfunction

		function void add(logic [2:0] k, logic [47:0] m, logic [31:0] ip, logic [3:0] ifc,
				logic [15:0] h, logic [10:0] len);
			arpc_pkg::out_t r;
			r.kind = k;
			r.mac_out = m;
			r.ip_out = ip;
			r.iface_out = ifc;
			r.handle_out = h;
			r.len_out = len;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function int depth(int r);
			int c;
			c = 0;
			for (int s = 0; s < N_PKT; s++)
				if (pkt_vld[s] && pkt_req[s] == r) c++;
			return c;
		endfunction

		// Release every packet of a request in queue order, then free it.
		function void release_req(int r, logic [2:0] k, logic [47:0] m);
			for (int pos = 0; pos < N_PKT; pos++)
				for (int s = 0; s < N_PKT; s++)
					if (pkt_vld[s] && pkt_req[s] == r && pkt_pos[s] == pos) begin
						add(k, m, req_ip[r], req_if[r], pkt_hdl[s], pkt_len[s]);
						pkt_vld[s] = 0;
					end
			req_vld[r] = 0;
		endfunction

		function void note_command(arpc_pkg::in_t c);
			int hit, slot, r, fr, fs;
			batch.delete();
			case (c.cmd)
				arpc_pkg::CMD_LOOKUP: begin
					hit = -1;
					for (int i = 0; i < N_ENT && hit < 0; i++)
						if (ent_vld[i] && ent_ip[i] == c.ip_addr) hit = i;
					if (hit >= 0) add(arpc_pkg::KIND_HIT, ent_mac[hit], c.ip_addr, '0, '0, '0);
					else add(arpc_pkg::KIND_MISS, '0, c.ip_addr, '0, '0, '0);
				end
				arpc_pkg::CMD_INSERT: begin
					slot = 0;
					for (int i = 0; i < N_ENT; i++)
						if (!ent_vld[i]) begin
							slot = i;
							break;
						end
					ent_vld[slot] = 1;
					ent_ip[slot] = c.ip_addr;
					ent_mac[slot] = c.mac_addr;
					ent_born[slot] = ticks;
					for (int q = 0; q < N_REQ; q++)
						if (req_vld[q] && req_ip[q] == c.ip_addr && depth(q) > 0)
							release_req(q, arpc_pkg::KIND_FWD, c.mac_addr);
				end
				arpc_pkg::CMD_APPEND: begin
					r = -1;
					fr = -1;
					fs = -1;
					for (int i = 0; i < N_REQ; i++) begin
						if (req_vld[i] && req_ip[i] == c.ip_addr && r < 0) r = i;
						if (!req_vld[i] && fr < 0) fr = i;
					end
					for (int s = 0; s < N_PKT; s++)
						if (!pkt_vld[s]) begin
							fs = s;
							break;
						end
					if (fs < 0 || (r < 0 && fr < 0)) begin
						add(arpc_pkg::KIND_DROP, '0, c.ip_addr, c.iface_id, c.pkt_handle,
							c.pkt_len);
					end else begin
						if (r < 0) begin
							r = fr;
							req_vld[r] = 1;
							req_ip[r] = c.ip_addr;
							req_if[r] = c.iface_id;
							req_sent[r] = ticks;
							req_tries[r] = '0;
							add(arpc_pkg::KIND_SEND, '0, c.ip_addr, c.iface_id, '0, '0);
						end
						pkt_pos[fs] = depth(r);
						pkt_vld[fs] = 1;
						pkt_req[fs] = r;
						pkt_hdl[fs] = c.pkt_handle;
						pkt_len[fs] = c.pkt_len;
					end
				end
				default: begin
					ticks = ticks + 32'd1;
					for (int i = 0; i < N_ENT; i++)
						if (ent_vld[i] && (ticks - ent_born[i]) > {16'd0, timeout})
							ent_vld[i] = 0;
					for (int q = 0; q < N_REQ; q++) begin
						if (!req_vld[q] || depth(q) == 0) continue;
						if ((ticks - req_sent[q]) < {24'd0, interval}) continue;
						if (req_tries[q] < limit) begin
							add(arpc_pkg::KIND_SEND, '0, req_ip[q], req_if[q], '0, '0);
							req_tries[q] = req_tries[q] + 4'd1;
							req_sent[q] = ticks;
						end else begin
							release_req(q, arpc_pkg::KIND_UNREACH, '0);
						end
					end
				end
			endcase
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) owed.push_back(batch[i]);
		endfunction

		function void check_result(arpc_pkg::out_t got);
			arpc_pkg::out_t e;
			if (owed.size() == 0) begin
				$error("unexpected result: kind %0d ip %h", got.kind, got.ip_out);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, got.kind);
				errors++;
			end
			if (got.mac_out !== e.mac_out) begin
				$error("mac_out: expected %h, got %h", e.mac_out, got.mac_out);
				errors++;
			end
			if (got.ip_out !== e.ip_out) begin
				$error("ip_out: expected %h, got %h", e.ip_out, got.ip_out);
				errors++;
			end
			if (got.iface_out !== e.iface_out) begin
				$error("iface_out: expected %0d, got %0d", e.iface_out, got.iface_out);
				errors++;
			end
			if (got.handle_out !== e.handle_out) begin
				$error("handle_out: expected %h, got %h", e.handle_out, got.handle_out);
				errors++;
			end
			if (got.len_out !== e.len_out) begin
				$error("len_out: expected %0d, got %0d", e.len_out, got.len_out);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	arpc_pkg::in_t in_item;
	logic out_valid;
	logic out_stall;
	arpc_pkg::out_t out_item;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;

	arp_scoreboard sb;
	int tx_pct;
	int rx_pct;
	int hold_cnt;
	int quiet;
	logic [31:0] ip_pool[6];

	arp_cache_with_pending_requests_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: random stall, long hold-off on request, check every transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic arpc_pkg::in_t make_cmd(logic [1:0] c, logic [31:0] ip, logic [47:0] m,
			logic [3:0] ifc, logic [15:0] h, logic [10:0] len);
		arpc_pkg::in_t x;
		x.cmd = c;
		x.ip_addr = ip;
		x.mac_addr = m;
		x.iface_id = ifc;
		x.pkt_handle = h;
		x.pkt_len = len;
		return x;
	endfunction

	task automatic send(arpc_pkg::in_t x);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= x;
		do @(posedge clk); while (in_stall);
		sb.note_command(x);
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_regs(logic [15:0] tmo, logic [15:0] ivl, logic [15:0] lim);
		drain_all();
		write_reg(arpc_pkg::REG_ENTRY_TIMEOUT, tmo);
		write_reg(arpc_pkg::REG_RETRY_INTERVAL, ivl);
		write_reg(arpc_pkg::REG_RETRY_LIMIT, lim);
	endtask

	task automatic random_phase(int n, bit squeeze);
		arpc_pkg::in_t x;
		logic [31:0] ip;
		logic [1:0] c;
		int pick;
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		for (int k = 0; k < n; k++) begin
			if (squeeze && k == n / 3) hold_cnt = 400;
			if (squeeze && k == 2 * n / 3) begin
				in_valid <= 1'b0;
				while (sb.owed.size() != 0) @(posedge clk);
			end
			ip = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(5)];
			pick = $urandom_range(99);
			c = pick < 25 ? arpc_pkg::CMD_LOOKUP : pick < 43 ? arpc_pkg::CMD_INSERT :
				pick < 80 ? arpc_pkg::CMD_APPEND : arpc_pkg::CMD_TICK;
			x = make_cmd(c, ip, 48'({$urandom, $urandom}), 4'($urandom), 16'($urandom),
				11'($urandom));
			send(x);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = arpc_pkg::REG_ENTRY_TIMEOUT;
		cfg_data = '0;
		tx_pct = 0;
		rx_pct = 0;
		hold_cnt = 0;
		quiet = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: misses, new and joined requests, forwarding, aging, expiry, drops.
		send(make_cmd(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 4'h0, 16'h0, 11'h0));
		send(make_cmd(arpc_pkg::CMD_APPEND, 32'h0, 48'h0, 4'hf, 16'hffff, 11'h7ff));
		send(make_cmd(arpc_pkg::CMD_APPEND, 32'h0, 48'h0, 4'h3, 16'h0000, 11'h000));
		send(make_cmd(arpc_pkg::CMD_INSERT, 32'h0, 48'hffff_ffff_ffff, 4'h0, 16'h0, 11'h0));
		send(make_cmd(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 4'h0, 16'h0, 11'h0));
		send(make_cmd(arpc_pkg::CMD_INSERT, 32'hffff_ffff, 48'h0, 4'hf, 16'hffff, 11'h7ff));
		send(make_cmd(arpc_pkg::CMD_LOOKUP, 32'hffff_ffff, 48'h0, 4'h0, 16'h0, 11'h0));
		send(make_cmd(arpc_pkg::CMD_APPEND, 32'h1234_5678, 48'h0, 4'h5, 16'h00aa, 11'h040));
		for (int i = 0; i < 8; i++)
			send(make_cmd(arpc_pkg::CMD_APPEND, 32'h0a00_0000 + 32'(i), 48'h0, 4'(i),
				16'(i), 11'(i)));
		for (int i = 0; i < 7; i++)
			send(make_cmd(arpc_pkg::CMD_TICK, 32'h0, 48'h0, 4'h0, 16'h0, 11'h0));
		send(make_cmd(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 4'h0, 16'h0, 11'h0));

		set_regs(16'd1, 16'd1, 16'd0);
		random_phase(110, 1'b1);
		tx_pct = 76;
		set_regs(16'd65535, 16'd255, 16'd15);
		random_phase(110, 1'b0);
		tx_pct = 0;
		rx_pct = 76;
		set_regs(16'd4, 16'd2, 16'd2);
		random_phase(110, 1'b0);
		tx_pct = 29;
		rx_pct = 29;
		set_regs(16'd15, 16'd1, 16'd4);
		random_phase(110, 1'b0);

		drain_all();
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
